/* rtl/core/subtractive_lagged_random_generator_assert.svh */
// Assertion macros for the subtractive lagged random generator.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef SUBTRACTIVE_LAGGED_RANDOM_GENERATOR_ASSERT_SVH
`define SUBTRACTIVE_LAGGED_RANDOM_GENERATOR_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define SLRG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define SLRG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/slrg_pkg.sv */
// Package for the subtractive lagged random generator.
// Holds constants, controller types and the modular subtract; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slrg_pkg;

    localparam int TABLE_LEN = 55;
    localparam int ADDR_W    = 6;
    localparam int VAL_W     = 30;
    localparam int SEED_W    = 31;

    localparam logic [VAL_W-1:0]  MODULUS   = 30'd1000000000;
    localparam logic [SEED_W-1:0] MODULUS_S = 31'd1000000000;
    localparam logic [SEED_W-1:0] SEED_BASE = 31'd161803398;

    localparam logic [ADDR_W-1:0] SLOT_LAST    = 6'd55;
    localparam logic [ADDR_W-1:0] FILL_STRIDE  = 6'd21;
    localparam logic [ADDR_W-1:0] FILL_STEPS   = 6'd54;
    localparam logic [ADDR_W-1:0] TRAIL_START  = 6'd31;
    localparam logic [ADDR_W-1:0] WARM_J_START = 6'd32;
    localparam logic [1:0]        WARM_PASS_LAST = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_INIT,
        ST_FILL,
        ST_WARM_RD,
        ST_WARM_WR,
        ST_DRAW_RD,
        ST_DRAW_WR
    } state_t;

    typedef struct packed {
        logic latch_seed;
        logic seed_init;
        logic fill;
        logic warm_rd;
        logic warm_wr;
        logic draw_rd;
        logic draw_wr;
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic warm_last;
        logic seeded;
        logic out_free;
    } status_t;

    function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[VAL_W])
        begin
            return d[VAL_W-1:0] + MODULUS;
        end
        return d[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/slrg_ctrl.sv */
// Controller state machine for the subtractive lagged random generator.
// Depends on slrg_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module slrg_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             kind,
    input  wire slrg_pkg::status_t status,
    output logic                  in_ready,
    output slrg_pkg::cmd_t        cmd
);

    slrg_pkg::state_t state_reg;
    slrg_pkg::state_t state_next;
    logic             need_seed;

    assign need_seed = kind || !status.seeded;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slrg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slrg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = need_seed ? slrg_pkg::ST_SEED_INIT : slrg_pkg::ST_DRAW_WR;
                end
            end
            slrg_pkg::ST_SEED_INIT:
            begin
                state_next = slrg_pkg::ST_FILL;
            end
            slrg_pkg::ST_FILL:
            begin
                if (status.fill_last)
                begin
                    state_next = slrg_pkg::ST_WARM_RD;
                end
            end
            slrg_pkg::ST_WARM_RD:
            begin
                state_next = slrg_pkg::ST_WARM_WR;
            end
            slrg_pkg::ST_WARM_WR:
            begin
                state_next = status.warm_last ? slrg_pkg::ST_DRAW_RD : slrg_pkg::ST_WARM_RD;
            end
            slrg_pkg::ST_DRAW_RD:
            begin
                state_next = slrg_pkg::ST_DRAW_WR;
            end
            slrg_pkg::ST_DRAW_WR:
            begin
                if (status.out_free)
                begin
                    state_next = slrg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slrg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            slrg_pkg::ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.latch_seed = in_valid;
                cmd.draw_rd    = in_valid && !need_seed;
            end
            slrg_pkg::ST_SEED_INIT:
            begin
                cmd.seed_init = 1'b1;
            end
            slrg_pkg::ST_FILL:
            begin
                cmd.fill = 1'b1;
            end
            slrg_pkg::ST_WARM_RD:
            begin
                cmd.warm_rd = 1'b1;
            end
            slrg_pkg::ST_WARM_WR:
            begin
                cmd.warm_wr = 1'b1;
            end
            slrg_pkg::ST_DRAW_RD:
            begin
                cmd.draw_rd = 1'b1;
            end
            slrg_pkg::ST_DRAW_WR:
            begin
                cmd.draw_wr = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/slrg_datapath.sv */
// Datapath for the subtractive lagged random generator: lag table memory,
// seeding counters, pointers and output register. Depends on slrg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slrg_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire slrg_pkg::cmd_t                cmd,
    input  wire logic [slrg_pkg::SEED_W-1:0]   seed_magnitude,
    input  wire logic                          out_ready,
    output slrg_pkg::status_t                  status,
    output logic                               out_valid,
    output logic [slrg_pkg::VAL_W-1:0]         value
);

    logic [slrg_pkg::VAL_W-1:0]  mem [slrg_pkg::TABLE_LEN];

    logic [slrg_pkg::SEED_W-1:0] seed_diff_reg;
    logic [slrg_pkg::VAL_W-1:0]  cur_reg;
    logic [slrg_pkg::VAL_W-1:0]  prev_reg;
    logic [slrg_pkg::ADDR_W-1:0] fill_slot_reg;
    logic [slrg_pkg::ADDR_W-1:0] fill_cnt_reg;
    logic [slrg_pkg::ADDR_W-1:0] warm_i_reg;
    logic [slrg_pkg::ADDR_W-1:0] warm_j_reg;
    logic [1:0]                  pass_reg;
    logic [slrg_pkg::ADDR_W-1:0] lead_reg;
    logic [slrg_pkg::ADDR_W-1:0] trail_reg;
    logic                        seeded_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [slrg_pkg::VAL_W-1:0]  value_reg;
    logic [slrg_pkg::VAL_W-1:0]  rd_a_reg;
    logic [slrg_pkg::VAL_W-1:0]  rd_b_reg;

    logic [slrg_pkg::SEED_W-1:0] seed_diff;
    logic [slrg_pkg::VAL_W-1:0]  seed_cur;
    logic [slrg_pkg::ADDR_W:0]   slot_sum;
    logic [slrg_pkg::ADDR_W-1:0] fill_slot_next;
    logic [slrg_pkg::ADDR_W-1:0] lead_inc;
    logic [slrg_pkg::ADDR_W-1:0] trail_inc;
    logic [slrg_pkg::VAL_W-1:0]  diff_rd;
    logic                        re;
    logic                        we;
    logic [slrg_pkg::ADDR_W-1:0] raddr_a;
    logic [slrg_pkg::ADDR_W-1:0] raddr_b;
    logic [slrg_pkg::ADDR_W-1:0] waddr;
    logic [slrg_pkg::VAL_W-1:0]  wdata;
    logic                        warm_i_last;

    // Every seed uses its absolute difference from the base constant.
    assign seed_diff = (seed_magnitude >= slrg_pkg::SEED_BASE)
                     ? seed_magnitude - slrg_pkg::SEED_BASE
                     : slrg_pkg::SEED_BASE - seed_magnitude;

    always_comb
    begin
        logic [slrg_pkg::SEED_W-1:0] reduced;
        reduced = (seed_diff_reg >= slrg_pkg::MODULUS_S)
                ? seed_diff_reg - slrg_pkg::MODULUS_S
                : seed_diff_reg;
        seed_cur = reduced[slrg_pkg::VAL_W-1:0];
    end

    assign slot_sum       = {1'b0, fill_slot_reg} + {1'b0, slrg_pkg::FILL_STRIDE};
    assign fill_slot_next = (slot_sum >= {1'b0, slrg_pkg::SLOT_LAST})
                          ? slrg_pkg::ADDR_W'(slot_sum - {1'b0, slrg_pkg::SLOT_LAST})
                          : slot_sum[slrg_pkg::ADDR_W-1:0];

    assign lead_inc  = (lead_reg >= slrg_pkg::SLOT_LAST) ? 6'd1 : lead_reg + 6'd1;
    assign trail_inc = (trail_reg >= slrg_pkg::SLOT_LAST) ? 6'd1 : trail_reg + 6'd1;

    assign diff_rd     = slrg_pkg::sub_mod(rd_a_reg, rd_b_reg);
    assign warm_i_last = (warm_i_reg == slrg_pkg::SLOT_LAST);

    // Table addresses are slot numbers minus one.
    always_comb
    begin
        re      = cmd.warm_rd || cmd.draw_rd;
        raddr_a = cmd.warm_rd ? warm_i_reg - 6'd1 : lead_inc - 6'd1;
        raddr_b = cmd.warm_rd ? warm_j_reg - 6'd1 : trail_inc - 6'd1;
        we      = cmd.seed_init || cmd.fill || cmd.warm_wr || cmd.draw_wr;
        waddr   = lead_reg - 6'd1;
        wdata   = diff_rd;
        if (cmd.seed_init)
        begin
            waddr = slrg_pkg::SLOT_LAST - 6'd1;
            wdata = seed_cur;
        end
        else if (cmd.fill)
        begin
            waddr = fill_slot_reg - 6'd1;
            wdata = prev_reg;
        end
        else if (cmd.warm_wr)
        begin
            waddr = warm_i_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[raddr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_seed)
        begin
            seed_diff_reg <= seed_diff;
        end
        if (cmd.seed_init)
        begin
            cur_reg  <= seed_cur;
            prev_reg <= 30'd1;
        end
        else if (cmd.fill)
        begin
            cur_reg  <= prev_reg;
            prev_reg <= slrg_pkg::sub_mod(cur_reg, prev_reg);
        end
        if (cmd.draw_wr)
        begin
            value_reg <= diff_rd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_slot_reg <= '0;
            fill_cnt_reg  <= '0;
            warm_i_reg    <= '0;
            warm_j_reg    <= '0;
            pass_reg      <= '0;
            lead_reg      <= '0;
            trail_reg     <= slrg_pkg::TRAIL_START;
            seeded_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.seed_init)
            begin
                fill_slot_reg <= slrg_pkg::FILL_STRIDE;
                fill_cnt_reg  <= 6'd1;
                warm_i_reg    <= 6'd1;
                warm_j_reg    <= slrg_pkg::WARM_J_START;
                pass_reg      <= '0;
            end
            if (cmd.fill)
            begin
                fill_slot_reg <= fill_slot_next;
                fill_cnt_reg  <= fill_cnt_reg + 6'd1;
            end
            if (cmd.warm_wr)
            begin
                warm_i_reg <= warm_i_last ? 6'd1 : warm_i_reg + 6'd1;
                warm_j_reg <= (warm_j_reg == slrg_pkg::SLOT_LAST) ? 6'd1 : warm_j_reg + 6'd1;
                if (warm_i_last)
                begin
                    pass_reg <= pass_reg + 2'd1;
                end
                if (status.warm_last)
                begin
                    lead_reg   <= '0;
                    trail_reg  <= slrg_pkg::TRAIL_START;
                    seeded_reg <= 1'b1;
                end
            end
            if (cmd.draw_rd)
            begin
                lead_reg  <= lead_inc;
                trail_reg <= trail_inc;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.draw_wr)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.fill_last = (fill_cnt_reg == slrg_pkg::FILL_STEPS);
    assign status.warm_last = warm_i_last && (pass_reg == slrg_pkg::WARM_PASS_LAST);
    assign status.seeded    = seeded_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule

`default_nettype wire

/* rtl/core/subtractive_lagged_random_generator.sv */
// Top level of the subtractive lagged random generator (55-word lag table).
// Instantiates slrg_ctrl and slrg_datapath; uses slrg_pkg and the assert header.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   kind, seed_magnitude
//   out      out_valid / out_ready value
//
// A draw reads both lag entries from the two-read, one-write table memory in the
// transfer cycle; its write state subtracts and writes back before a new item is taken.
// A reseed (or the first item after reset) covers the transfer cycle, 1 seed setup,
// 54 fill steps, 4 x 55 warm-up subtractions, each a read then a write state, and a draw.
// Reset clears the pointers to 0 and 31 and marks the table as unseeded.
// A stalled output holds a draw in its write cycle while one value waits in the output.
`timescale 1ns / 1ps
`default_nettype none

`include "subtractive_lagged_random_generator_assert.svh"

module subtractive_lagged_random_generator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        kind,
    input  wire logic [slrg_pkg::SEED_W-1:0] seed_magnitude,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [slrg_pkg::VAL_W-1:0]       value
);

    slrg_pkg::cmd_t    cmd;
    slrg_pkg::status_t status;

    slrg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    slrg_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .seed_magnitude (seed_magnitude),
        .out_ready      (out_ready),
        .status         (status),
        .out_valid      (out_valid),
        .value          (value)
    );

    `SLRG_ASSERT_SAME(a_value_range, out_valid, value < slrg_pkg::MODULUS, "value out of range")
    `SLRG_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken during work")
    `SLRG_ASSERT_SAME(a_out_from_draw, $rose(out_valid), $past(cmd.draw_wr), "result without draw")

endmodule

`default_nettype wire

/* test/tb_subtractive_lagged_random_generator.sv */
// Self-checking testbench for subtractive_lagged_random_generator.
// A clocked driver and monitor run against an internal model of the 55-word lag table.
// Depends only on slrg_pkg and the generator RTL.
`timescale 1ns / 1ps

module tb_subtractive_lagged_random_generator;

    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_RESEED = 1'b1;

    localparam longint MOD_L        = slrg_pkg::MODULUS;
    localparam int     RANDOM_ITEMS = 800;

    typedef struct packed {
        logic                        kind;
        logic [slrg_pkg::SEED_W-1:0] seed;
    } draw_req_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic                        kind = KIND_DRAW;
    logic [slrg_pkg::SEED_W-1:0] seed_magnitude = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [slrg_pkg::VAL_W-1:0]  value;

    draw_req_t                  pending_draws[$];
    logic [slrg_pkg::VAL_W-1:0] expected_values[$];

    logic [slrg_pkg::VAL_W-1:0]  lag_tab [1:slrg_pkg::TABLE_LEN];
    logic [slrg_pkg::ADDR_W-1:0] lead_slot = '0;
    logic [slrg_pkg::ADDR_W-1:0] trail_slot = slrg_pkg::TRAIL_START;
    logic                        table_seeded = 1'b0;

    int unsigned send_idle_pct = 7;
    int unsigned recv_stall_pct = 70;
    int          mismatches = 0;
    int          draws_accepted = 0;
    int          reseeds_accepted = 0;
    int          values_checked = 0;

    subtractive_lagged_random_generator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .seed_magnitude (seed_magnitude),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .value          (value)
    );

    always #4 clk = ~clk;

    function automatic void seed_lag_table(input logic [slrg_pkg::SEED_W-1:0] mag);
        longint cur;
        longint prev;
        longint diff;
        int     slot;
        int     step;
        int     pass;
        int     j;
        cur = longint'(slrg_pkg::SEED_BASE) - longint'(mag);
        if (cur < 0)
        begin
            cur = -cur;
        end
        cur = cur % MOD_L;
        lag_tab[slrg_pkg::TABLE_LEN] = slrg_pkg::VAL_W'(cur);
        prev = 1;
        for (step = 1; step <= int'(slrg_pkg::FILL_STEPS); step++)
        begin
            slot = (int'(slrg_pkg::FILL_STRIDE) * step) % slrg_pkg::TABLE_LEN;
            lag_tab[slot] = slrg_pkg::VAL_W'(prev);
            prev = cur - prev;
            if (prev < 0)
            begin
                prev += MOD_L;
            end
            cur = longint'(lag_tab[slot]);
        end
        for (pass = 0; pass < 4; pass++)
        begin
            for (j = 1; j <= slrg_pkg::TABLE_LEN; j++)
            begin
                diff = longint'(lag_tab[j])
                     - longint'(lag_tab[1 + (j + 30) % slrg_pkg::TABLE_LEN]);
                if (diff < 0)
                begin
                    diff += MOD_L;
                end
                lag_tab[j] = slrg_pkg::VAL_W'(diff);
            end
        end
        lead_slot = '0;
        trail_slot = slrg_pkg::TRAIL_START;
        table_seeded = 1'b1;
    endfunction

    function automatic logic [slrg_pkg::VAL_W-1:0] next_lagged_value(input draw_req_t req);
        longint diff;
        if (req.kind == KIND_RESEED || !table_seeded)
        begin
            seed_lag_table(req.seed);
        end
        lead_slot = (lead_slot >= slrg_pkg::SLOT_LAST) ? slrg_pkg::ADDR_W'(1)
                                                       : lead_slot + slrg_pkg::ADDR_W'(1);
        trail_slot = (trail_slot >= slrg_pkg::SLOT_LAST) ? slrg_pkg::ADDR_W'(1)
                                                         : trail_slot + slrg_pkg::ADDR_W'(1);
        diff = longint'(lag_tab[lead_slot]) - longint'(lag_tab[trail_slot]);
        if (diff < 0)
        begin
            diff += MOD_L;
        end
        lag_tab[lead_slot] = slrg_pkg::VAL_W'(diff);
        return slrg_pkg::VAL_W'(diff);
    endfunction

    function automatic draw_req_t random_draw_req();
        draw_req_t req;
        req.kind = ($urandom_range(24) == 0) ? KIND_RESEED : KIND_DRAW;
        case ($urandom_range(7))
            0: req.seed = slrg_pkg::SEED_W'($urandom_range(15));
            1: req.seed = slrg_pkg::SEED_BASE + slrg_pkg::SEED_W'($urandom_range(8)) - 31'd4;
            2: req.seed = ~slrg_pkg::SEED_W'($urandom_range(255));
            default: req.seed = slrg_pkg::SEED_W'($urandom);
        endcase
        return req;
    endfunction

    task automatic queue_draw(input logic k, input logic [slrg_pkg::SEED_W-1:0] s);
        draw_req_t req;
        req.kind = k;
        req.seed = s;
        pending_draws.push_back(req);
    endtask

    task automatic wait_until_drained();
        while (pending_draws.size() != 0 || in_valid || expected_values.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_values.push_back(next_lagged_value('{kind, seed_magnitude}));
                draws_accepted++;
                if (kind == KIND_RESEED)
                begin
                    reseeds_accepted++;
                end
            end
            if (!in_valid || in_ready)
            begin
                if (pending_draws.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid       <= 1'b1;
                    kind           <= pending_draws[0].kind;
                    seed_magnitude <= pending_draws[0].seed;
                    void'(pending_draws.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_values.size() == 0)
                begin
                    $error("value: unexpected transfer, actual %0d", value);
                    mismatches++;
                end
                else
                begin
                    if (value !== expected_values[0])
                    begin
                        $error("value mismatch: expected %0d, actual %0d",
                               expected_values[0], value);
                        mismatches++;
                    end
                    void'(expected_values.pop_front());
                    values_checked++;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int i;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The first transfer after reset is a plain draw and must seed the table itself.
        queue_draw(KIND_DRAW, 31'd12345);
        queue_draw(KIND_DRAW, '1);
        queue_draw(KIND_RESEED, '0);
        queue_draw(KIND_DRAW, '0);
        queue_draw(KIND_RESEED, '1);
        queue_draw(KIND_RESEED, slrg_pkg::SEED_BASE);
        queue_draw(KIND_RESEED, slrg_pkg::SEED_BASE + 31'd1);
        queue_draw(KIND_RESEED, slrg_pkg::SEED_BASE - 31'd1);
        queue_draw(KIND_RESEED, slrg_pkg::SEED_BASE + slrg_pkg::MODULUS_S);
        queue_draw(KIND_RESEED, slrg_pkg::SEED_BASE + slrg_pkg::MODULUS_S + 31'd5);
        for (i = 0; i < 14; i++)
        begin
            queue_draw(KIND_DRAW, slrg_pkg::SEED_W'($urandom));
        end
        wait_until_drained();

        for (i = 0; i < RANDOM_ITEMS / 3; i++)
        begin
            pending_draws.push_back(random_draw_req());
        end
        wait_until_drained();

        send_idle_pct = 70;
        recv_stall_pct = 7;
        for (i = 0; i < RANDOM_ITEMS / 3; i++)
        begin
            pending_draws.push_back(random_draw_req());
        end
        wait_until_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (i = 0; i < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); i++)
        begin
            pending_draws.push_back(random_draw_req());
        end
        wait_until_drained();
        repeat (16) @(posedge clk);

        if (expected_values.size() != 0)
        begin
            $error("value: %0d expected transfers never arrived", expected_values.size());
            mismatches++;
        end
        $display("Checked %0d values from %0d accepted draws, %0d of them explicit reseeds,",
                 values_checked, draws_accepted, reseeds_accepted);
        $display("under sender-heavy, receiver-heavy and back-to-back pacing.");
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
